>>> sv/ksss_pkg.sv
// ============================================================================
// ksss_pkg: shared types and constants for keyframe stagger stable sort
// Register indexes, set descriptor, back-end sequencer states.
// ============================================================================
`default_nettype none

package ksss_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int DESC_CNT_W   = 7;   // holds a count up to the largest set size
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD = 1'd1;

  // One finished set, handed from front to back
  typedef struct packed {
    logic [DESC_CNT_W-1:0] count;
    logic [DATA_W-1:0]     step;
    logic                  fold;
  } set_desc_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PRE_RD,
    B_PRE_MUL,
    B_PRE_ADD,
    B_SCAN,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

>>> sv/ksss_if.sv
// ============================================================================
// ksss_in_if / ksss_out_if: keyframe word channels
// Valid/ready channels with keyframe payloads.
// ============================================================================
`default_nettype none

interface ksss_in_if;
  logic                         valid;
  logic                         ready;
  logic [ksss_pkg::DATA_W-1:0]  key_time;
  logic [ksss_pkg::DATA_W-1:0]  key_value;
  logic                         set_end;
  modport source (output valid, key_time, key_value, set_end, input ready);
  modport sink   (input valid, key_time, key_value, set_end, output ready);
endinterface

interface ksss_out_if;
  logic                         valid;
  logic                         ready;
  logic [ksss_pkg::DATA_W-1:0]  sorted_time;
  logic [ksss_pkg::DATA_W-1:0]  sorted_value;
  logic                         run_end;
  modport source (output valid, sorted_time, sorted_value, run_end, input ready);
  modport sink   (input valid, sorted_time, sorted_value, run_end, output ready);
endinterface

`default_nettype wire

>>> sv/ksss_ram.sv
// ============================================================================
// ksss_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module ksss_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/ksss_fifo.sv
// ============================================================================
// ksss_fifo: short descriptor queue between front and back
// Two-entry register queue.
// ============================================================================
`default_nettype none

module ksss_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;

  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && cnt_r != 2'd2) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push && cnt_r != 2'd2) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && not_empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push && cnt_r != 2'd2} - {1'b0, pop && not_empty};
    end
  end

endmodule

`default_nettype wire

>>> sv/ksss_front.sv
// ============================================================================
// ksss_front: keyframe loader
// Stores incoming words, detects set end, snapshots configuration.
// ============================================================================
`default_nettype none

module ksss_front #(
  parameter int MaxKeys = ksss_pkg::MAX_KEYS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  ksss_in_if.sink                           in_ch,
  input  wire logic [ksss_pkg::DATA_W-1:0]  step,
  input  wire logic                         fold,
  input  wire logic                         set_done,
  output logic                              wr_en,
  output logic [$clog2(MaxKeys)-1:0]        wr_addr,
  output logic                              desc_push,
  output ksss_pkg::set_desc_t               desc
);

  localparam int CW = $clog2(MaxKeys + 1);
  localparam int AW = $clog2(MaxKeys);

  logic [CW-1:0] cnt_r, cnt_inc;
  logic          busy_r;
  logic          acc, last;

  assign in_ch.ready = !busy_r;
  assign acc         = in_ch.valid && !busy_r;
  assign cnt_inc     = cnt_r + CW'(1);
  assign last        = in_ch.set_end || (cnt_inc == CW'(MaxKeys));

  assign wr_en      = acc;
  assign wr_addr    = cnt_r[AW-1:0];
  assign desc_push  = acc && last;
  assign desc.count = ksss_pkg::DESC_CNT_W'(cnt_inc);
  assign desc.step  = step;
  assign desc.fold  = fold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r <= last ? '0 : cnt_inc;
      end
      // stores are single-buffered: hold off until the back end is through
      if (desc_push) begin
        busy_r <= 1'b1;
      end else if (set_done) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/ksss_back.sv
// ============================================================================
// ksss_back: stagger and ordered emission
// Shifts stored times, then picks the next key per scan and emits it.
// ============================================================================
`default_nettype none

module ksss_back #(
  parameter int MaxKeys = ksss_pkg::MAX_KEYS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         desc_avail,
  input  wire ksss_pkg::set_desc_t          desc,
  output logic                              desc_pop,
  output logic                              set_done,
  output logic [$clog2(MaxKeys)-1:0]        time_raddr,
  input  wire logic [ksss_pkg::DATA_W-1:0]  time_rdata,
  output logic                              key_we,
  output logic [$clog2(MaxKeys)-1:0]        key_waddr,
  output logic [ksss_pkg::DATA_W-1:0]       key_wdata,
  output logic [$clog2(MaxKeys)-1:0]        scan_raddr,
  input  wire logic [ksss_pkg::DATA_W-1:0]  key_rdata,
  input  wire logic [ksss_pkg::DATA_W-1:0]  val_rdata,
  ksss_out_if.source                        out_ch
);

  localparam int CW = $clog2(MaxKeys + 1);
  localparam int AW = $clog2(MaxKeys);
  localparam int DW = ksss_pkg::DATA_W;
  localparam int PW = CW + 1 + DW;   // product width
  localparam int SW = PW + 1;        // sum width

  ksss_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0]        n_r, j_r, iss_r, pos_r, rd_idx_r;
  logic [DW-1:0]        step_r;
  logic                 fold_r, sort_en;
  logic                 rd_v_r;
  logic signed [PW-1:0] prod_r;
  logic [DW-1:0]        traw_r;
  logic [CW-1:0]        rev, fidx;
  logic signed [SW-1:0] sum;
  logic [DW-1:0]        shifted;
  logic                 best_v_r, have_last_r;
  logic [DW-1:0]        best_t_r, best_val_r, last_t_r;
  logic [CW-1:0]        best_i_r, last_i_r;
  logic                 after_last, better;
  logic                 out_v_r, out_free;
  logic [DW-1:0]        out_t_r, out_val_r;
  logic                 out_end_r;

  function automatic logic key_lt(input logic en, input logic [DW-1:0] a,
                                  input logic [CW-1:0] ia, input logic [DW-1:0] b,
                                  input logic [CW-1:0] ib);
    if (en) begin
      return ($signed(a) < $signed(b)) || (a == b && ia < ib);
    end
    return ia < ib;
  endfunction

  assign sort_en = (n_r >= CW'(2)) && (step_r != '0);

  // ping-pong index fold
  assign rev  = n_r - CW'(1) - j_r;
  assign fidx = (fold_r && rev < j_r) ? rev : j_r;

  assign sum = SW'(signed'(traw_r)) + SW'(prod_r);
  always_comb begin
    if (sum[SW-1:DW-1] == '0 || sum[SW-1:DW-1] == '1) begin
      shifted = sum[DW-1:0];
    end else if (sum[SW-1]) begin
      shifted = {1'b1, {(DW-1){1'b0}}};
    end else begin
      shifted = {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign time_raddr = j_r[AW-1:0];
  assign key_waddr  = j_r[AW-1:0];
  assign key_wdata  = sort_en ? shifted : traw_r;
  assign scan_raddr = iss_r[AW-1:0];

  assign after_last = !have_last_r ||
                      key_lt(sort_en, last_t_r, last_i_r, key_rdata, rd_idx_r);
  assign better     = !best_v_r ||
                      key_lt(sort_en, key_rdata, rd_idx_r, best_t_r, best_i_r);

  assign out_free     = !out_v_r || out_ch.ready;
  assign out_ch.valid        = out_v_r;
  assign out_ch.sorted_time  = out_t_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.run_end      = out_end_r;

  always_comb begin
    state_nxt = state_r;
    desc_pop  = 1'b0;
    set_done  = 1'b0;
    key_we    = 1'b0;
    unique case (state_r)
      ksss_pkg::B_IDLE: begin
        if (desc_avail) begin
          desc_pop  = 1'b1;
          state_nxt = ksss_pkg::B_PRE_RD;
        end
      end
      ksss_pkg::B_PRE_RD:  state_nxt = ksss_pkg::B_PRE_MUL;
      ksss_pkg::B_PRE_MUL: state_nxt = ksss_pkg::B_PRE_ADD;
      ksss_pkg::B_PRE_ADD: begin
        key_we    = 1'b1;
        state_nxt = (j_r == n_r - CW'(1)) ? ksss_pkg::B_SCAN : ksss_pkg::B_PRE_RD;
      end
      ksss_pkg::B_SCAN: begin
        if (iss_r == n_r && !rd_v_r) begin
          state_nxt = ksss_pkg::B_EMIT;
        end
      end
      ksss_pkg::B_EMIT: begin
        if (out_free) begin
          if (pos_r == n_r - CW'(1)) begin
            set_done  = 1'b1;
            state_nxt = ksss_pkg::B_IDLE;
          end else begin
            state_nxt = ksss_pkg::B_SCAN;
          end
        end
      end
      default: state_nxt = ksss_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ksss_pkg::B_IDLE;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == ksss_pkg::B_SCAN) && (iss_r != n_r);
      if (state_r == ksss_pkg::B_EMIT && out_free) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= iss_r;
    unique case (state_r)
      ksss_pkg::B_IDLE: begin
        n_r         <= CW'(desc.count);
        step_r      <= desc.step;
        fold_r      <= desc.fold;
        j_r         <= '0;
        pos_r       <= '0;
        iss_r       <= '0;
        best_v_r    <= 1'b0;
        have_last_r <= 1'b0;
      end
      ksss_pkg::B_PRE_RD: begin
      end
      ksss_pkg::B_PRE_MUL: begin
        traw_r <= time_rdata;
        prod_r <= signed'({1'b0, fidx}) * signed'(step_r);
      end
      ksss_pkg::B_PRE_ADD: begin
        j_r <= j_r + CW'(1);
      end
      ksss_pkg::B_SCAN: begin
        if (iss_r != n_r) begin
          iss_r <= iss_r + CW'(1);
        end
        if (rd_v_r && after_last && better) begin
          best_v_r   <= 1'b1;
          best_t_r   <= key_rdata;
          best_i_r   <= rd_idx_r;
          best_val_r <= val_rdata;
        end
      end
      ksss_pkg::B_EMIT: begin
        if (out_free) begin
          out_t_r     <= best_t_r;
          out_val_r   <= best_val_r;
          out_end_r   <= (pos_r == n_r - CW'(1));
          last_t_r    <= best_t_r;
          last_i_r    <= best_i_r;
          have_last_r <= 1'b1;
          pos_r       <= pos_r + CW'(1);
          iss_r       <= '0;
          best_v_r    <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/keyframe_stagger_stable_sort.sv
// ============================================================================
// keyframe_stagger_stable_sort: staggered keyframe set, stably sorted by time
// Top level: configuration registers, front loader, queue, back sorter, RAMs.
// ============================================================================
// Keyframe words are collected until one carries set_end (or MaxKeys words
// arrive); no words are accepted while a set is being sorted and emitted.
// Key i's time is shifted by index * stagger_step (index folded ping-pong when
// fold_mode is set), saturated to 32 bits, and the set is emitted in stable
// ascending time order with run_end on its final word. Sets under two keys or
// with a zero step come out in arrival order. One input word is taken per
// cycle while loading; then each key's shifted time is computed through the
// B_PRE_RD, B_PRE_MUL and B_PRE_ADD states, and for each emitted key the set
// is read over in one scan (one RAM read per cycle). Registers are sampled
// when a set closes.
`default_nettype none

module keyframe_stagger_stable_sort #(
  parameter int MaxKeys = ksss_pkg::MAX_KEYS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ksss_in_if.sink                              in_ch,
  ksss_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [ksss_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ksss_pkg::DATA_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(MaxKeys);
  localparam int DW = ksss_pkg::DATA_W;

  // configuration registers
  logic [DW-1:0] step_r;
  logic          fold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      fold_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ksss_pkg::REG_STEP: step_r <= cfg_wdata;
        ksss_pkg::REG_FOLD: fold_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  logic                 wr_en, desc_push, desc_pop, desc_avail, set_done;
  logic [AW-1:0]        wr_addr, time_raddr, key_waddr, scan_raddr;
  ksss_pkg::set_desc_t  push_desc, pop_desc;
  logic                 key_we;
  logic [DW-1:0]        key_wdata, time_rdata, key_rdata, val_rdata;

  ksss_front #(.MaxKeys(MaxKeys)) u_front (
    .clk, .rst_n, .in_ch,
    .step     (step_r),
    .fold     (fold_r),
    .set_done,
    .wr_en, .wr_addr, .desc_push,
    .desc     (push_desc)
  );

  // raw times and values as they arrive
  ksss_ram #(.W(DW), .D(MaxKeys)) u_time_ram (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(in_ch.key_time),
    .raddr(time_raddr), .rdata(time_rdata)
  );

  ksss_ram #(.W(DW), .D(MaxKeys)) u_val_ram (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(in_ch.key_value),
    .raddr(scan_raddr), .rdata(val_rdata)
  );

  // sort keys (shifted times)
  ksss_ram #(.W(DW), .D(MaxKeys)) u_key_ram (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(scan_raddr), .rdata(key_rdata)
  );

  ksss_fifo #(.W($bits(ksss_pkg::set_desc_t))) u_queue (
    .clk, .rst_n,
    .push      (desc_push),
    .push_data (push_desc),
    .pop       (desc_pop),
    .not_empty (desc_avail),
    .pop_data  (pop_desc)
  );

  ksss_back #(.MaxKeys(MaxKeys)) u_back (
    .clk, .rst_n,
    .desc_avail,
    .desc (pop_desc),
    .desc_pop, .set_done,
    .time_raddr, .time_rdata,
    .key_we, .key_waddr, .key_wdata,
    .scan_raddr, .key_rdata, .val_rdata,
    .out_ch
  );

endmodule

`default_nettype wire

>>> sv/ksss_chk.sv
// ============================================================================
// ksss_chk: port-level checks for keyframe stagger stable sort
// Bound to the top level.
// ============================================================================
`default_nettype none

module ksss_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_set_end,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_run_end
);

  // a closed set blocks loading
  a_set_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_set_end |=> !in_ready)
    else $error("input still open after set end");

  // nothing follows the final word of a run until a new set closes
  a_run_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_run_end |=> !out_valid)
    else $error("word emitted right after run end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

endmodule

bind keyframe_stagger_stable_sort ksss_chk u_ksss_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_set_end  (in_ch.set_end),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_run_end (out_ch.run_end)
);

`default_nettype wire
